// ----- rtl/pks_pkg.sv -----
// Shared types, constants and helper functions of the periodic knot setter.
`default_nettype none

package pks_pkg;

    localparam int IW  = 16;
    localparam int VW  = 48;
    localparam int DW  = 32;
    localparam int PAW = 4;

    typedef logic signed [IW-1:0] idx_t;
    typedef logic signed [VW-1:0] val_t;
    typedef logic signed [DW-1:0] knot_t;

    localparam idx_t I_ONE  = idx_t'(1);
    localparam idx_t I_ZERO = idx_t'(0);

    localparam logic [1:0] REG_DEGREE = 2'd0;
    localparam logic [1:0] REG_LAST   = 2'd1;
    localparam logic [1:0] REG_PERIOD = 2'd2;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_SET   = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        RET_W1,
        RET_W2,
        RET_FIN
    } ret_t;

    typedef enum logic [5:0] {
        OP_NOP, OP_LATCH, OP_DISPATCH,
        OP_W1_CHK, OP_W1_CMP, OP_W1_V, OP_W1_MCHK, OP_W1_MCMP, OP_W1_POST,
        OP_W2_INIT, OP_W2_CHK, OP_W2_CMP, OP_W2_MCHK, OP_W2_MCMP, OP_W2_VRD,
        OP_W2_V, OP_W2_POST,
        OP_PP_LOAD, OP_PA_WR, OP_PB_INIT, OP_PB_CHK, OP_PB_WR,
        OP_PC_INIT, OP_PC_CHK, OP_PC_WR,
        OP_FIX_LOAD, OP_FIX_WR,
        OP_DN_INIT, OP_DN_PREV, OP_DN_CHK, OP_DN_CMP,
        OP_UP_INIT, OP_UP_PREV, OP_UP_CHK, OP_UP_CMP,
        OP_SD_CHK, OP_SD_CMP, OP_SU_CHK, OP_SU_CMP,
        OP_RESULT
    } dp_op_t;

    typedef enum logic [5:0] {
        ST_IDLE, ST_DISPATCH,
        ST_W1_CHK, ST_W1_CMP, ST_W1_V, ST_W1_MCHK, ST_W1_MCMP, ST_W1_POST,
        ST_W2_INIT, ST_W2_CHK, ST_W2_CMP, ST_W2_MCHK, ST_W2_MCMP, ST_W2_VRD,
        ST_W2_V, ST_W2_POST,
        ST_PP_START, ST_PA_WR, ST_PB_INIT, ST_PB_CHK, ST_PB_WR,
        ST_PC_INIT, ST_PC_CHK, ST_PC_WR,
        ST_FIX_LOAD, ST_FIX_WR,
        ST_DN_INIT, ST_DN_PREV, ST_DN_CHK, ST_DN_CMP,
        ST_UP_INIT, ST_UP_PREV, ST_UP_CHK, ST_UP_CMP,
        ST_SD_CHK, ST_SD_CMP, ST_SU_CHK, ST_SU_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        dp_op_t op;
        logic   pp_final;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  rej;
        logic  w1_go;
        logic  tt_lt;
        logic  tt_gt;
        logic  eq_ref;
        logic  m1_more;
        logic  m2_more;
        logic  w2_go;
        logic  pm_zero;
        logic  pa_end;
        logic  pb_ok;
        logic  pb_wr;
        logic  pc_ok;
        logic  pc_wr;
        logic  kn_ne_pos;
        logic  dn_go;
        logic  up_go;
        logic  pos_gt_mult;
        logic  rv_gt_t;
        logic  pos_lt_lm1;
        logic  rv_le_t;
    } stat_t;

    typedef struct packed {
        logic [4:0]  degree;
        logic [5:0]  last;
        logic [30:0] period;
    } cfg_t;

    function automatic val_t sext_val(input knot_t x);
        return $signed({{(VW-DW){x[DW-1]}}, x});
    endfunction

    function automatic knot_t sat32(input val_t v);
        if (&v[VW-1:DW-1] || ~|v[VW-1:DW-1])
            return v[DW-1:0];
        else if (v[VW-1])
            return knot_t'({1'b1, {(DW-1){1'b0}}});
        else
            return knot_t'({1'b0, {(DW-1){1'b1}}});
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pks_regs.sv -----
// Configuration register bank behind the APB-style port.
`default_nettype none

module pks_regs
    import pks_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [PAW-1:0] paddr,
    input  wire logic [31:0]    pwdata,
    output logic      [31:0]    prdata,
    output logic                pready,
    output cfg_t                cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_stb;

    assign pready = 1'b1;
    assign wr_stb = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_stb)
        begin
            unique case (paddr[PAW-1:2])
                REG_DEGREE: cfg_next.degree = pwdata[4:0];
                REG_LAST:   cfg_next.last   = pwdata[5:0];
                REG_PERIOD: cfg_next.period = pwdata[30:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[PAW-1:2])
            REG_DEGREE: prdata = {27'd0, cfg_reg.degree};
            REG_LAST:   prdata = {26'd0, cfg_reg.last};
            REG_PERIOD: prdata = {1'b0, cfg_reg.period};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.degree <= 5'd3;
            cfg_reg.last   <= 6'd63;
            cfg_reg.period <= 31'd65536;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pks_ctrl.sv -----
// Sequencing state machine of the knot setter.
`default_nettype none

module pks_ctrl
    import pks_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  stat_t      stat,
    output logic       busy,
    output cmd_t       cmd
);

    state_t state_reg, state_next;
    ret_t   ret_reg, ret_next;

    function automatic state_t ret_target(input ret_t r);
        unique case (r)
            RET_W1:  return ST_W1_POST;
            RET_W2:  return ST_W2_POST;
            default: return ST_FIX_LOAD;
        endcase
    endfunction

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            ST_IDLE:     if (start) state_next = ST_DISPATCH;
            ST_DISPATCH: state_next = (stat.mode == MODE_SET && !stat.rej) ? ST_W1_CHK : ST_DONE;
            ST_W1_CHK:   state_next = stat.w1_go ? ST_W1_CMP : ST_W2_INIT;
            ST_W1_CMP:   state_next = stat.tt_lt ? ST_W1_V : ST_W2_INIT;
            ST_W1_V:     state_next = ST_W1_MCHK;
            ST_W1_MCHK:
            begin
                if (stat.m1_more)
                    state_next = ST_W1_MCMP;
                else
                begin
                    state_next = ST_PP_START;
                    ret_next   = RET_W1;
                end
            end
            ST_W1_MCMP:
            begin
                if (stat.eq_ref)
                    state_next = ST_W1_MCHK;
                else
                begin
                    state_next = ST_PP_START;
                    ret_next   = RET_W1;
                end
            end
            ST_W1_POST:  state_next = ST_W1_CHK;
            ST_W2_INIT:  state_next = ST_W2_CHK;
            ST_W2_CHK:
            begin
                if (stat.w2_go)
                    state_next = ST_W2_CMP;
                else
                begin
                    state_next = ST_PP_START;
                    ret_next   = RET_FIN;
                end
            end
            ST_W2_CMP:
            begin
                if (stat.tt_gt)
                    state_next = ST_W2_MCHK;
                else
                begin
                    state_next = ST_PP_START;
                    ret_next   = RET_FIN;
                end
            end
            ST_W2_MCHK:  state_next = stat.m2_more ? ST_W2_MCMP : ST_W2_VRD;
            ST_W2_MCMP:  state_next = stat.eq_ref ? ST_W2_MCHK : ST_W2_VRD;
            ST_W2_VRD:   state_next = ST_W2_V;
            ST_W2_V:
            begin
                state_next = ST_PP_START;
                ret_next   = RET_W2;
            end
            ST_W2_POST:  state_next = ST_W2_CHK;
            ST_PP_START: state_next = ST_PA_WR;
            ST_PA_WR:
            begin
                if (stat.pm_zero)
                    state_next = ret_target(ret_reg);
                else if (stat.pa_end)
                    state_next = ST_PB_INIT;
            end
            ST_PB_INIT:  state_next = ST_PB_CHK;
            ST_PB_CHK:   state_next = stat.pb_ok ? ST_PB_WR : ST_PC_INIT;
            ST_PB_WR:    state_next = stat.pb_wr ? ST_PB_WR : ST_PB_CHK;
            ST_PC_INIT:  state_next = ST_PC_CHK;
            ST_PC_CHK:   state_next = stat.pc_ok ? ST_PC_WR : ret_target(ret_reg);
            ST_PC_WR:    state_next = stat.pc_wr ? ST_PC_WR : ST_PC_CHK;
            ST_FIX_LOAD: state_next = stat.kn_ne_pos ? ST_FIX_WR : ST_DN_INIT;
            ST_FIX_WR:   state_next = stat.pc_wr ? ST_FIX_WR : ST_DN_INIT;
            ST_DN_INIT:  state_next = ST_DN_PREV;
            ST_DN_PREV:  state_next = ST_DN_CHK;
            ST_DN_CHK:   state_next = stat.dn_go ? ST_DN_CMP : ST_UP_INIT;
            ST_DN_CMP:   state_next = ST_DN_CHK;
            ST_UP_INIT:  state_next = ST_UP_PREV;
            ST_UP_PREV:  state_next = ST_UP_CHK;
            ST_UP_CHK:   state_next = stat.up_go ? ST_UP_CMP : ST_SD_CHK;
            ST_UP_CMP:   state_next = ST_UP_CHK;
            ST_SD_CHK:   state_next = stat.pos_gt_mult ? ST_SD_CMP : ST_SU_CHK;
            ST_SD_CMP:   state_next = stat.rv_gt_t ? ST_SD_CHK : ST_SU_CHK;
            ST_SU_CHK:   state_next = stat.pos_lt_lm1 ? ST_SU_CMP : ST_DONE;
            ST_SU_CMP:   state_next = stat.rv_le_t ? ST_SU_CHK : ST_DONE;
            ST_DONE:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy         = (state_reg != ST_IDLE);
        cmd.pp_final = (ret_reg == RET_FIN);
        unique case (state_reg)
            ST_IDLE:     cmd.op = start ? OP_LATCH : OP_NOP;
            ST_DISPATCH: cmd.op = OP_DISPATCH;
            ST_W1_CHK:   cmd.op = OP_W1_CHK;
            ST_W1_CMP:   cmd.op = OP_W1_CMP;
            ST_W1_V:     cmd.op = OP_W1_V;
            ST_W1_MCHK:  cmd.op = OP_W1_MCHK;
            ST_W1_MCMP:  cmd.op = OP_W1_MCMP;
            ST_W1_POST:  cmd.op = OP_W1_POST;
            ST_W2_INIT:  cmd.op = OP_W2_INIT;
            ST_W2_CHK:   cmd.op = OP_W2_CHK;
            ST_W2_CMP:   cmd.op = OP_W2_CMP;
            ST_W2_MCHK:  cmd.op = OP_W2_MCHK;
            ST_W2_MCMP:  cmd.op = OP_W2_MCMP;
            ST_W2_VRD:   cmd.op = OP_W2_VRD;
            ST_W2_V:     cmd.op = OP_W2_V;
            ST_W2_POST:  cmd.op = OP_W2_POST;
            ST_PP_START: cmd.op = OP_PP_LOAD;
            ST_PA_WR:    cmd.op = OP_PA_WR;
            ST_PB_INIT:  cmd.op = OP_PB_INIT;
            ST_PB_CHK:   cmd.op = OP_PB_CHK;
            ST_PB_WR:    cmd.op = OP_PB_WR;
            ST_PC_INIT:  cmd.op = OP_PC_INIT;
            ST_PC_CHK:   cmd.op = OP_PC_CHK;
            ST_PC_WR:    cmd.op = OP_PC_WR;
            ST_FIX_LOAD: cmd.op = OP_FIX_LOAD;
            ST_FIX_WR:   cmd.op = OP_FIX_WR;
            ST_DN_INIT:  cmd.op = OP_DN_INIT;
            ST_DN_PREV:  cmd.op = OP_DN_PREV;
            ST_DN_CHK:   cmd.op = OP_DN_CHK;
            ST_DN_CMP:   cmd.op = OP_DN_CMP;
            ST_UP_INIT:  cmd.op = OP_UP_INIT;
            ST_UP_PREV:  cmd.op = OP_UP_PREV;
            ST_UP_CHK:   cmd.op = OP_UP_CHK;
            ST_UP_CMP:   cmd.op = OP_UP_CMP;
            ST_SD_CHK:   cmd.op = OP_SD_CHK;
            ST_SD_CMP:   cmd.op = OP_SD_CMP;
            ST_SU_CHK:   cmd.op = OP_SU_CHK;
            ST_SU_CMP:   cmd.op = OP_SU_CMP;
            ST_DONE:     cmd.op = OP_RESULT;
            default:     cmd.op = OP_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= RET_W1;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pks_dp.sv -----
// Datapath of the knot setter: knot memory, index and value registers, result register.
`default_nettype none

module pks_dp
    import pks_pkg::*;
#(
    parameter int MAX_KNOTS = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  cmd_t             cmd,
    input  cfg_t             cfg,
    input  wire logic [1:0]  mode_in,
    input  wire logic [5:0]  index_in,
    input  wire logic [5:0]  mult_in,
    input  wire knot_t       value_in,
    output stat_t            stat,
    output logic             done,
    output logic             status,
    output logic [5:0]       interval_index,
    output knot_t            read_value
);

    localparam int AW    = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
    localparam int LIMIT = 2 * MAX_KNOTS;
    localparam int SW    = $clog2(LIMIT) + 1;
    localparam idx_t I_MAX  = idx_t'(MAX_KNOTS);
    localparam idx_t I_MAXM = idx_t'(MAX_KNOTS - 1);
    localparam idx_t I_63   = idx_t'(63);

    knot_t knot_mem [MAX_KNOTS];

    mode_t         mode_reg, mode_next;
    knot_t         t_reg, t_next;
    idx_t          mult_reg, mult_next;
    idx_t          pos_reg, pos_next;
    idx_t          kn_reg, kn_next;
    val_t          tt_reg, tt_next;
    logic [SW-1:0] steps_reg, steps_next;
    idx_t          m_reg, m_next;
    knot_t         v_reg, v_next;
    knot_t         ref_reg, ref_next;
    idx_t          base_reg, base_next;
    idx_t          pm_reg, pm_next;
    val_t          pval_reg, pval_next;
    val_t          pv_reg, pv_next;
    idx_t          b_reg, b_next;
    idx_t          i_reg, i_next;
    knot_t         prev_reg, prev_next;
    knot_t         rd_q_reg;
    logic          rd_oob_reg;
    logic          rej_reg, rej_next;
    logic          done_reg, done_next;
    logic          status_reg, status_next;
    logic [5:0]    intv_reg, intv_next;
    knot_t         rdv_reg, rdv_next;

    logic  rd_en, wr_en;
    idx_t  rd_idx, wr_idx, tmp;
    knot_t wr_data, rv;
    val_t  rv_ext, per_ext;
    idx_t  last_i, deg_i, k_i;
    logic  rd_oob, wr_oob, i_oob;

    assign last_i  = $signed({{(IW-6){1'b0}}, cfg.last});
    assign deg_i   = $signed({{(IW-5){1'b0}}, cfg.degree});
    assign k_i     = last_i - deg_i - deg_i;
    assign per_ext = $signed({{(VW-31){1'b0}}, cfg.period});
    assign rv      = rd_oob_reg ? knot_t'(0) : rd_q_reg;
    assign rv_ext  = sext_val(rv);
    assign rd_oob  = (rd_idx < I_ZERO) || (rd_idx >= I_MAX);
    assign wr_oob  = (wr_idx < I_ZERO) || (wr_idx >= I_MAX);
    assign i_oob   = (i_reg < I_ZERO) || (i_reg >= I_MAX);

    always_comb
    begin
        stat.mode        = mode_reg;
        stat.rej         = (last_i <= deg_i + deg_i + deg_i) || (mult_reg > k_i)
                           || (pos_reg >= last_i);
        stat.w1_go       = (steps_reg < SW'(LIMIT)) && (kn_reg > I_ONE);
        stat.tt_lt       = tt_reg < rv_ext;
        stat.tt_gt       = tt_reg > rv_ext;
        stat.eq_ref      = rv == ref_reg;
        stat.m1_more     = (kn_reg - I_ONE - m_reg) > I_ZERO;
        stat.m2_more     = (kn_reg + I_ONE + m_reg) < last_i;
        stat.w2_go       = (steps_reg < SW'(LIMIT)) && (kn_reg < last_i - I_ONE);
        stat.pm_zero     = pm_reg == I_ZERO;
        stat.pa_end      = i_reg == base_reg;
        stat.pb_ok       = (b_reg - pm_reg) <= last_i;
        stat.pb_wr       = (i_reg <= b_reg) && (i_reg <= last_i);
        stat.pc_ok       = b_reg >= I_ZERO;
        stat.pc_wr       = (i_reg > b_reg - pm_reg) && (i_reg >= I_ZERO);
        stat.kn_ne_pos   = kn_reg != pos_reg;
        stat.dn_go       = i_reg >= I_ZERO;
        stat.up_go       = i_reg <= last_i;
        stat.pos_gt_mult = pos_reg > mult_reg;
        stat.rv_gt_t     = rv > t_reg;
        stat.pos_lt_lm1  = pos_reg < last_i - I_ONE;
        stat.rv_le_t     = rv <= t_reg;
    end

    always_comb
    begin
        mode_next   = mode_reg;
        t_next      = t_reg;
        mult_next   = mult_reg;
        pos_next    = pos_reg;
        kn_next     = kn_reg;
        tt_next     = tt_reg;
        steps_next  = steps_reg;
        m_next      = m_reg;
        v_next      = v_reg;
        ref_next    = ref_reg;
        base_next   = base_reg;
        pm_next     = pm_reg;
        pval_next   = pval_reg;
        pv_next     = pv_reg;
        b_next      = b_reg;
        i_next      = i_reg;
        prev_next   = prev_reg;
        rej_next    = rej_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        intv_next   = intv_reg;
        rdv_next    = rdv_reg;
        rd_en       = 1'b0;
        rd_idx      = I_ZERO;
        wr_en       = 1'b0;
        wr_idx      = I_ZERO;
        wr_data     = knot_t'(0);
        tmp         = I_ZERO;
        unique case (cmd.op)
            OP_NOP: ;
            OP_LATCH:
            begin
                mode_next = mode_t'(mode_in);
                pos_next  = $signed({{(IW-6){1'b0}}, index_in});
                mult_next = $signed({{(IW-6){1'b0}}, mult_in});
                t_next    = value_in;
            end
            OP_DISPATCH:
            begin
                wr_en      = (mode_reg == MODE_WRITE);
                wr_idx     = pos_reg;
                wr_data    = t_reg;
                rd_en      = 1'b1;
                rd_idx     = pos_reg;
                steps_next = '0;
                // The position moves during a set, so the verdict is kept from here.
                rej_next   = stat.rej;
                if (pos_reg - mult_reg + I_ONE < deg_i)
                begin
                    kn_next = pos_reg + k_i;
                    tt_next = sext_val(t_reg) + per_ext;
                end
                else if (pos_reg > last_i - deg_i)
                begin
                    kn_next = pos_reg - k_i;
                    tt_next = sext_val(t_reg) - per_ext;
                end
                else
                begin
                    kn_next = pos_reg;
                    tt_next = sext_val(t_reg);
                end
            end
            OP_W1_CHK:
            begin
                rd_en  = 1'b1;
                rd_idx = kn_reg - mult_reg;
            end
            OP_W1_CMP:
            begin
                rd_en  = 1'b1;
                rd_idx = kn_reg - I_ONE;
            end
            OP_W1_V:
            begin
                v_next   = rv;
                ref_next = rv;
                m_next   = I_ONE;
            end
            OP_W1_MCHK:
            begin
                rd_en  = 1'b1;
                rd_idx = kn_reg - I_ONE - m_reg;
            end
            OP_W1_MCMP:
            begin
                if (rv == ref_reg)
                    m_next = m_reg + I_ONE;
            end
            OP_W1_POST:
            begin
                tmp        = kn_reg - m_reg;
                pos_next   = pos_reg - m_reg;
                steps_next = steps_reg + SW'(1);
                if (tmp <= m_reg)
                begin
                    kn_next = tmp + k_i;
                    tt_next = tt_reg + per_ext;
                end
                else
                begin
                    kn_next = tmp;
                end
            end
            OP_W2_INIT: steps_next = '0;
            OP_W2_CHK:
            begin
                rd_en  = 1'b1;
                rd_idx = kn_reg + I_ONE;
            end
            OP_W2_CMP:
            begin
                ref_next = rv;
                m_next   = I_ONE;
            end
            OP_W2_MCHK:
            begin
                rd_en  = 1'b1;
                rd_idx = kn_reg + I_ONE + m_reg;
            end
            OP_W2_MCMP:
            begin
                if (rv == ref_reg)
                    m_next = m_reg + I_ONE;
            end
            OP_W2_VRD:
            begin
                rd_en  = 1'b1;
                rd_idx = kn_reg + m_reg;
            end
            OP_W2_V: v_next = rv;
            OP_W2_POST:
            begin
                tmp        = kn_reg + m_reg;
                pos_next   = pos_reg + m_reg;
                steps_next = steps_reg + SW'(1);
                if (tmp >= last_i)
                begin
                    kn_next = tmp - k_i;
                    tt_next = tt_reg - per_ext;
                end
                else
                begin
                    kn_next = tmp;
                end
            end
            OP_PP_LOAD:
            begin
                tmp       = cmd.pp_final ? mult_reg : m_reg;
                base_next = kn_reg;
                pm_next   = tmp;
                pval_next = cmd.pp_final ? tt_reg : sext_val(v_reg);
                pv_next   = cmd.pp_final ? tt_reg : sext_val(v_reg);
                i_next    = kn_reg - tmp + I_ONE;
            end
            OP_PA_WR:
            begin
                wr_en   = (pm_reg != I_ZERO);
                wr_idx  = i_reg;
                wr_data = sat32(pv_reg);
                i_next  = i_reg + I_ONE;
            end
            OP_PB_INIT:
            begin
                b_next  = base_reg + k_i;
                pv_next = pval_reg + per_ext;
            end
            OP_PB_CHK: i_next = b_reg - pm_reg + I_ONE;
            OP_PB_WR:
            begin
                if (stat.pb_wr)
                begin
                    wr_en   = 1'b1;
                    wr_idx  = i_reg;
                    wr_data = sat32(pv_reg);
                    i_next  = i_reg + I_ONE;
                end
                else
                begin
                    b_next  = b_reg + k_i;
                    pv_next = pv_reg + per_ext;
                end
            end
            OP_PC_INIT:
            begin
                b_next  = base_reg - k_i;
                pv_next = pval_reg - per_ext;
            end
            OP_PC_CHK: i_next = b_reg;
            OP_PC_WR:
            begin
                if (stat.pc_wr)
                begin
                    wr_en   = 1'b1;
                    wr_idx  = i_reg;
                    wr_data = sat32(pv_reg);
                    i_next  = i_reg - I_ONE;
                end
                else
                begin
                    b_next  = b_reg - k_i;
                    pv_next = pv_reg - per_ext;
                end
            end
            OP_FIX_LOAD:
            begin
                b_next  = pos_reg;
                pm_next = mult_reg;
                pv_next = sext_val(t_reg);
                i_next  = pos_reg;
            end
            OP_FIX_WR:
            begin
                wr_en   = stat.pc_wr;
                wr_idx  = i_reg;
                wr_data = sat32(pv_reg);
                i_next  = i_reg - I_ONE;
            end
            OP_DN_INIT:
            begin
                tmp    = (pos_reg - I_ONE > I_MAXM) ? I_MAXM : pos_reg - I_ONE;
                i_next = tmp;
                rd_en  = 1'b1;
                rd_idx = tmp + I_ONE;
            end
            OP_DN_PREV: prev_next = rv;
            OP_DN_CHK:
            begin
                rd_en  = 1'b1;
                rd_idx = i_reg;
            end
            OP_DN_CMP:
            begin
                if (rv > prev_reg)
                begin
                    wr_en   = 1'b1;
                    wr_idx  = i_reg;
                    wr_data = prev_reg;
                end
                else
                begin
                    prev_next = rv;
                end
                if (i_oob)
                    prev_next = knot_t'(0);
                i_next = i_reg - I_ONE;
            end
            OP_UP_INIT:
            begin
                tmp    = (pos_reg + I_ONE < I_ZERO) ? I_ZERO : pos_reg + I_ONE;
                i_next = tmp;
                rd_en  = 1'b1;
                rd_idx = tmp - I_ONE;
            end
            OP_UP_PREV: prev_next = rv;
            OP_UP_CHK:
            begin
                rd_en  = 1'b1;
                rd_idx = i_reg;
            end
            OP_UP_CMP:
            begin
                if (rv < prev_reg)
                begin
                    wr_en   = 1'b1;
                    wr_idx  = i_reg;
                    wr_data = prev_reg;
                end
                else
                begin
                    prev_next = rv;
                end
                if (i_oob)
                    prev_next = knot_t'(0);
                i_next = i_reg + I_ONE;
            end
            OP_SD_CHK:
            begin
                rd_en  = 1'b1;
                rd_idx = pos_reg;
            end
            OP_SD_CMP:
            begin
                if (rv > t_reg)
                    pos_next = pos_reg - I_ONE;
            end
            OP_SU_CHK:
            begin
                rd_en  = 1'b1;
                rd_idx = pos_reg + I_ONE;
            end
            OP_SU_CMP:
            begin
                if (rv <= t_reg)
                    pos_next = pos_reg + I_ONE;
            end
            OP_RESULT:
            begin
                done_next   = 1'b1;
                status_next = (mode_reg == MODE_NONE) || (mode_reg == MODE_SET && rej_reg);
                rdv_next    = (mode_reg == MODE_READ) ? rv : knot_t'(0);
                if (mode_reg == MODE_SET && !rej_reg)
                begin
                    if (pos_reg < I_ZERO)
                        intv_next = 6'd0;
                    else if (pos_reg > I_63)
                        intv_next = 6'd63;
                    else
                        intv_next = pos_reg[5:0];
                end
                else
                begin
                    intv_next = 6'd0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_oob)
            knot_mem[wr_idx[AW-1:0]] <= wr_data;
        if (rd_en)
        begin
            rd_q_reg   <= knot_mem[rd_idx[AW-1:0]];
            rd_oob_reg <= rd_oob;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        t_reg      <= t_next;
        mult_reg   <= mult_next;
        pos_reg    <= pos_next;
        kn_reg     <= kn_next;
        tt_reg     <= tt_next;
        steps_reg  <= steps_next;
        m_reg      <= m_next;
        v_reg      <= v_next;
        ref_reg    <= ref_next;
        base_reg   <= base_next;
        pm_reg     <= pm_next;
        pval_reg   <= pval_next;
        pv_reg     <= pv_next;
        b_reg      <= b_next;
        i_reg      <= i_next;
        prev_reg   <= prev_next;
        rej_reg    <= rej_next;
        status_reg <= status_next;
        intv_reg   <= intv_next;
        rdv_reg    <= rdv_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign interval_index = intv_reg;
    assign read_value     = rdv_reg;

endmodule

`default_nettype wire

// ----- rtl/periodic_knot_setter_top.sv -----
// Top level of the periodic knot setter: register bank, controller and datapath.
`default_nettype none

// The block keeps the knot vector of a closed B-spline in signed Q16.16 and serves one
// transaction at a time on a start/busy command channel. A transaction is taken at a
// rising edge where start is high and busy is low; mode selects a knot write, a knot
// read or a closed-knot set. Every transaction yields exactly one result, shown on
// status, interval_index and read_value for a single cycle while done is high. The
// receiver cannot hold results off, so results are never stalled or queued.
// A write or read, an unused mode and a rejected set pass from acceptance through the
// dispatch and done states to the registered result. A set walks the knot memory
// through its single read port and single write port, one access per cycle; each
// compared knot takes a memory read and its registered output. Its run time grows
// with the knots scanned in the two shifting walks, the knots written by each
// periodic replication and the monotonicity passes over 0..last, and each walk is
// bounded by the walk limit of 2*MAX_KNOTS steps. The user must write configuration
// through the APB-style port only while idle; the block itself does not enforce it.
// pready is tied high. Reset clears the controller and the done strobe and restores
// the register defaults; the knot memory holds no reset value and is undefined until
// written.

module periodic_knot_setter_top
    import pks_pkg::*;
#(
    parameter int MAX_KNOTS = 64
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire logic [1:0]     mode,
    input  wire logic [5:0]     knot_index,
    input  wire logic [5:0]     multiplicity,
    input  wire logic signed [31:0] knot_value,
    output logic                done,
    output logic                status,
    output logic [5:0]          interval_index,
    output logic signed [31:0]  read_value,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [PAW-1:0] paddr,
    input  wire logic [31:0]    pwdata,
    output logic      [31:0]    prdata,
    output logic                pready
);

    // Configuration seen by the datapath.
    cfg_t  cfg;
    // Micro-operation from the controller and flags back from the datapath.
    cmd_t  cmd;
    stat_t stat;

    pks_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pks_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    pks_dp #(
        .MAX_KNOTS (MAX_KNOTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg            (cfg),
        .mode_in        (mode),
        .index_in       (knot_index),
        .mult_in        (multiplicity),
        .value_in       (knot_value),
        .stat           (stat),
        .done           (done),
        .status         (status),
        .interval_index (interval_index),
        .read_value     (read_value)
    );

endmodule

`default_nettype wire

// ----- rtl/pks_checker.sv -----
// Port-level checks of the knot setter and their binding to the top level.
`default_nettype none

module pks_checker
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               done,
    input wire logic               status,
    input wire logic [5:0]         interval_index,
    input wire logic signed [31:0] read_value
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted transaction");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe lasted more than one cycle");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && status |-> interval_index == 6'd0 && read_value == 32'sd0)
        else $error("rejected result carries data");

    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("transaction ended without a result");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

endmodule

bind periodic_knot_setter_top pks_checker u_pks_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .status         (status),
    .interval_index (interval_index),
    .read_value     (read_value)
);

`default_nettype wire

// ----- tb/periodic_knot_setter_top_test.sv -----
// Self-checking testbench of the periodic knot setter: directed table, random traffic, checks.
`default_nettype none

module periodic_knot_setter_top_test;
    import pks_pkg::*;

    // Everything the block answers for one transaction.
    typedef struct {
        logic               status;
        logic [5:0]         interval;
        logic signed [31:0] value;
    } answer_t;

    // One row of the directed table. Where has_answer is set, the answer is typed in
    // by hand; every other row is checked against the knot vector model below.
    typedef struct {
        mode_t              op;
        logic [5:0]         index;
        logic [5:0]         mult;
        logic signed [31:0] value;
        bit                 has_answer;
        answer_t            answer;
    } plan_row_t;

    localparam int NUM_KNOTS  = 64;
    localparam int WALK_STEPS = 2 * NUM_KNOTS;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         mode;
    logic [5:0]         knot_index;
    logic [5:0]         multiplicity;
    logic signed [31:0] knot_value;
    logic               done;
    logic               status;
    logic [5:0]         interval_index;
    logic signed [31:0] read_value;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PAW-1:0]     paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    periodic_knot_setter_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .knot_index     (knot_index),
        .multiplicity   (multiplicity),
        .knot_value     (knot_value),
        .done           (done),
        .status         (status),
        .interval_index (interval_index),
        .read_value     (read_value),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Our own copy of the knot vector and of the configuration registers.
    int          knot_mem [NUM_KNOTS];
    logic [4:0]  cfg_degree;
    logic [5:0]  cfg_last;
    logic [30:0] cfg_period;

    // Answers still owed by the block, oldest first.
    answer_t     pending_answers [$];
    int          error_count;
    bit          allow_idle;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // ------------------------------------------------------------------
    // Knot vector model.
    // ------------------------------------------------------------------

    // Out-of-range accesses read as zero; stores saturate to 32 bits.
    function automatic longint knot_at(longint i);
        if (i < 0 || i >= NUM_KNOTS)
            return 0;
        return knot_mem[i];
    endfunction

    function automatic void store_knot(longint i, longint v);
        if (i < 0 || i >= NUM_KNOTS)
            return;
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        knot_mem[i] = int'(v);
    endfunction

    // Lay m copies of v ending at kn, then repeat them one period up and down for
    // every copy of the pattern that fits within 0..last.
    function automatic void replicate_knot(longint span, longint last, longint per,
                                           longint kn, longint m, longint v);
        longint i;
        longint j;
        for (i = 1 - m; i <= 0; i++)
            store_knot(kn + i, v);
        for (j = 1; kn + j * span - m <= last; j++)
            for (i = 1 - m; i <= 0 && kn + j * span + i <= last; i++)
                store_knot(kn + j * span + i, v + j * per);
        for (j = 1; kn - j * span >= 0; j++)
            for (i = 0; i < m && kn - j * span - i >= 0; i++)
                store_knot(kn - j * span - i, v - j * per);
    endfunction

    // Insert a closed knot; returns 1 when the request is refused.
    function automatic bit insert_closed_knot(longint pos, longint mult, longint t,
                                              output longint interval);
        longint deg;
        longint last;
        longint per;
        longint span;
        longint kn;
        longint tt;
        longint m;
        longint i;
        longint steps;
        deg  = cfg_degree;
        last = cfg_last;
        per  = cfg_period;
        span = last - 2 * deg;
        interval = 0;
        if (last <= 3 * deg || mult > span || pos < 0 || pos >= last)
            return 1'b1;

        // Move the working position into the central period.
        if (pos - mult + 1 < deg)
        begin
            kn = pos + span;
            tt = t + per;
        end
        else if (pos > last - deg)
        begin
            kn = pos - span;
            tt = t - per;
        end
        else
        begin
            kn = pos;
            tt = t;
        end

        // Walk downwards past larger neighbours, shifting whole runs of equal knots.
        for (steps = 0; steps < WALK_STEPS && kn > 1 && tt < knot_at(kn - mult); steps++)
        begin
            m = 1;
            while (kn - 1 - m > 0 && knot_at(kn - 1 - m) == knot_at(kn - 1))
                m++;
            replicate_knot(span, last, per, kn, m, knot_at(kn - 1));
            kn  -= m;
            pos -= m;
            if (kn <= m)
            begin
                kn += span;
                tt += per;
            end
        end
        // And upwards past smaller ones.
        for (steps = 0; steps < WALK_STEPS && kn < last - 1 && tt > knot_at(kn + 1); steps++)
        begin
            m = 1;
            while (kn + 1 + m < last && knot_at(kn + 1 + m) == knot_at(kn + 1))
                m++;
            replicate_knot(span, last, per, kn, m, knot_at(kn + m));
            kn  += m;
            pos += m;
            if (kn >= last)
            begin
                kn -= span;
                tt -= per;
            end
        end

        replicate_knot(span, last, per, kn, mult, tt);
        if (kn != pos)
            for (i = 0; i < mult && pos - i >= 0; i++)
                store_knot(pos - i, t);

        // Force the vector to be non-decreasing on both sides of the new knot.
        for (i = pos - 1; i >= 0; i--)
            if (knot_at(i) > knot_at(i + 1))
                store_knot(i, knot_at(i + 1));
        for (i = pos + 1; i <= last; i++)
            if (knot_at(i) < knot_at(i - 1))
                store_knot(i, knot_at(i - 1));

        while (pos > mult && knot_at(pos) > t)
            pos--;
        while (pos < last - 1 && knot_at(pos + 1) <= t)
            pos++;
        if (pos < 0)
            pos = 0;
        if (pos > 63)
            pos = 63;
        interval = pos;
        return 1'b0;
    endfunction

    // Work out the block's answer to one transaction and update the model.
    function automatic answer_t model_transaction(logic [1:0] op, logic [5:0] index,
                                                  logic [5:0] mult, logic signed [31:0] v);
        answer_t a;
        longint  interval;
        a.status   = 1'b0;
        a.interval = '0;
        a.value    = '0;
        case (op)
            MODE_WRITE:
                store_knot(index, v);
            MODE_SET:
                if (insert_closed_knot(index, mult, v, interval))
                    a.status = 1'b1;
                else
                    a.interval = interval[5:0];
            MODE_READ:
                a.value = 32'(knot_at(index));
            default:
                a.status = 1'b1;
        endcase
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Drivers.
    // ------------------------------------------------------------------

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!allow_idle || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Present one transaction and wait until it is taken. Start is left high so that
    // a following transaction can come straight after; it is lowered only for a gap.
    task automatic send_transaction(logic [1:0] op, logic [5:0] index, logic [5:0] mult,
                                    logic signed [31:0] v, bit typed, answer_t typed_answer);
        int      gap;
        answer_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        mode         <= op;
        knot_index   <= index;
        multiplicity <= mult;
        knot_value   <= v;
        do
            @(posedge clk);
        while (busy);
        predicted = model_transaction(op, index, mult, v);
        pending_answers.push_back(typed ? typed_answer : predicted);
    endtask

    task automatic send(logic [1:0] op, logic [5:0] index, logic [5:0] mult,
                        logic signed [31:0] v);
        answer_t none;
        none = '{1'b0, 6'd0, 32'sd0};
        send_transaction(op, index, mult, v, 1'b0, none);
    endtask

    // Let the block fall idle: every answer in, then a few spare cycles.
    task automatic drain();
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] reg_index, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_index)
            REG_DEGREE: cfg_degree = data[4:0];
            REG_LAST:   cfg_last   = data[5:0];
            default:    cfg_period = data[30:0];
        endcase
    endtask

    task automatic configure(logic [4:0] deg, logic [5:0] last, logic [30:0] per);
        drain();
        write_register(REG_DEGREE, 32'(deg));
        write_register(REG_LAST, 32'(last));
        write_register(REG_PERIOD, 32'(per));
    endtask

    // Load the whole store with a non-decreasing vector; skipped or zero steps give repeated knots.
    task automatic load_vector(int max_step);
        longint v;
        int     i;
        v = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        for (i = 0; i < NUM_KNOTS; i++)
        begin
            send(MODE_WRITE, 6'(i), 6'd0, 32'(v));
            if ($urandom_range(0, 3) != 0)
                v += $urandom_range(0, max_step);
        end
    endtask

    // A random phase: mostly well-formed set requests near existing knots, with reads,
    // writes, refused requests and plain noise mixed in.
    task automatic random_phase(int count);
        int           n;
        int           r;
        int           span;
        logic [5:0]   index;
        logic [5:0]   mult;
        longint       v;
        span = int'(cfg_last) - 2 * int'(cfg_degree);
        for (n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55 && span > 0)
            begin
                index = 6'($urandom_range(0, cfg_last > 0 ? cfg_last - 1 : 0));
                mult  = 6'($urandom_range(1, span < 4 ? span : 4));
                v     = knot_at($urandom_range(0, cfg_last))
                        + longint'($urandom_range(0, 1 << 17)) - (1 << 16);
                send(MODE_SET, index, mult, 32'(v));
            end
            else if (r < 75)
                send(MODE_READ, 6'($urandom), 6'($urandom), 32'($urandom));
            else if (r < 85)
            begin
                index = 6'($urandom);
                v     = knot_at(index) + longint'($urandom_range(0, 1 << 12));
                send(MODE_WRITE, index, 6'($urandom), 32'(v));
            end
            else
                send(2'($urandom), 6'($urandom), 6'($urandom), 32'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Answer checker: every done cycle carries one answer.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: answer with nothing outstanding (status %0d interval %0d value %0d)",
                         $time, status, interval_index, read_value);
                error_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d, got %0d", $time, want.status, status);
                    error_count++;
                end
                if (interval_index !== want.interval)
                begin
                    $display("%0t: interval_index expected %0d, got %0d",
                             $time, want.interval, interval_index);
                    error_count++;
                end
                if (read_value !== want.value)
                begin
                    $display("%0t: read_value expected %0d, got %0d",
                             $time, want.value, read_value);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------

    initial
    begin
        plan_row_t plan [$];
        answer_t   refused;
        int        i;
        error_count  = 0;
        allow_idle   = 1'b1;
        cfg_degree   = 5'd3;
        cfg_last     = 6'd63;
        cfg_period   = 31'd65536;
        rst_n        = 1'b0;
        start        = 1'b0;
        mode         = MODE_WRITE;
        knot_index   = '0;
        multiplicity = '0;
        knot_value   = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every knot is written before anything can read it; a set with the reset
        // configuration touches the whole store.
        for (i = 0; i < NUM_KNOTS; i++)
            send(MODE_WRITE, 6'(i), 6'd1, 32'(i << 16));

        // Directed table at the reset configuration (degree 3, last 63, so K is 57).
        refused = '{1'b1, 6'd0, 32'sd0};
        plan.push_back('{MODE_WRITE, 6'd5, 6'd1, 32'sh7FFFFFFF, 1'b0, refused});
        plan.push_back('{MODE_READ, 6'd5, 6'd0, 32'sd0, 1'b1, '{1'b0, 6'd0, 32'sh7FFFFFFF}});
        plan.push_back('{MODE_WRITE, 6'd5, 6'd63, 32'sh80000000, 1'b0, refused});
        plan.push_back('{MODE_READ, 6'd5, 6'd0, 32'sd0, 1'b1, '{1'b0, 6'd0, 32'sh80000000}});
        plan.push_back('{MODE_WRITE, 6'd5, 6'd0, 32'sh00050000, 1'b0, refused});
        plan.push_back('{MODE_READ, 6'd5, 6'd0, 32'sd0, 1'b1, '{1'b0, 6'd0, 32'sh00050000}});
        plan.push_back('{MODE_NONE, 6'd63, 6'd63, 32'shFFFFFFFF, 1'b1, refused});
        // Refused requests: multiplicity above K, index at or beyond the last knot.
        plan.push_back('{MODE_SET, 6'd10, 6'd63, 32'sh000A0000, 1'b1, refused});
        plan.push_back('{MODE_SET, 6'd10, 6'd58, 32'sh000A0000, 1'b1, refused});
        plan.push_back('{MODE_SET, 6'd63, 6'd1, 32'sh003F0000, 1'b1, refused});
        // Accepted requests: plain, near the start and end wrap, walks both ways,
        // saturating values and the largest legal multiplicity.
        plan.push_back('{MODE_SET, 6'd20, 6'd1, 32'sh00148000, 1'b0, refused});
        plan.push_back('{MODE_SET, 6'd30, 6'd3, 32'sh001E0000, 1'b0, refused});
        plan.push_back('{MODE_SET, 6'd0, 6'd1, 32'sh00008000, 1'b0, refused});
        plan.push_back('{MODE_SET, 6'd62, 6'd2, 32'sh003E8000, 1'b0, refused});
        plan.push_back('{MODE_SET, 6'd25, 6'd1, 32'sh00300000, 1'b0, refused});
        plan.push_back('{MODE_SET, 6'd40, 6'd1, 32'sh00100000, 1'b0, refused});
        plan.push_back('{MODE_SET, 6'd30, 6'd1, 32'sh7FFFFFFF, 1'b0, refused});
        plan.push_back('{MODE_SET, 6'd30, 6'd1, 32'sh80000000, 1'b0, refused});
        plan.push_back('{MODE_SET, 6'd33, 6'd57, 32'sh00200000, 1'b0, refused});
        plan.push_back('{MODE_READ, 6'd0, 6'd0, 32'sd0, 1'b0, refused});
        plan.push_back('{MODE_READ, 6'd63, 6'd0, 32'sd0, 1'b0, refused});
        foreach (plan[k])
            send_transaction(plan[k].op, plan[k].index, plan[k].mult, plan[k].value,
                             plan[k].has_answer, plan[k].answer);

        // Random phases over a spread of settings, the extremes among them.
        load_vector(1 << 16);
        random_phase(300);

        configure(5'd1, 6'd63, 31'd1);
        allow_idle = 1'b0;
        load_vector(4);
        random_phase(150);
        allow_idle = 1'b1;

        configure(5'd20, 6'd63, 31'h7FFFFFFF);
        load_vector(1 << 24);
        random_phase(250);

        // Degree 21 and last 1 both leave no room: every set is refused.
        configure(5'd21, 6'd63, 31'd65536);
        random_phase(60);
        configure(5'd3, 6'd1, 31'd65536);
        random_phase(60);

        configure(5'd5, 6'd40, 31'd3 << 16);
        load_vector(1 << 14);
        random_phase(300);

        configure(5'd2, 6'd12, 31'd100000);
        load_vector(20000);
        random_phase(150);

        drain();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #40000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
